[sv/max_heap_priority_queue_core_assert.svh]
// assertion macros for the max-heap priority queue core
// included by the modules that carry concurrent checks; no other dependencies
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[sv/mhpq_pkg.sv]
// shared types and constants of the max-heap priority queue core
// no dependencies; imported by the sequencer and the top level
`default_nettype none
package mhpq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 128;
  localparam int unsigned ID_W           = 16;
  localparam int unsigned PRI_W          = 16;
  localparam int unsigned OCC_W          = 8;
  localparam int unsigned STATUS_W       = 2;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [PRI_W-1:0] pri;
  } task_t;

  typedef struct packed {
    logic                    command;
    logic [ID_W-1:0]         task_id;
    logic signed [PRI_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [ID_W-1:0]         out_task_id;
    logic signed [PRI_W-1:0] out_priority;
    logic [OCC_W-1:0]        occupancy;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage
`default_nettype wire

[sv/mhpq_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies; holds the heap entries
`default_nettype none
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/mhpq_seq.sv]
// heap sequencer: sift-up and sift-down over the heap ram with one shared comparator
// depends on mhpq_pkg and the assertion header
`default_nettype none
`include "max_heap_priority_queue_core_assert.svh"
module mhpq_seq #(
  parameter int unsigned HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire mhpq_pkg::seq_ctl_t                             ctl,
  input  wire mhpq_pkg::in_word_t                             req,
  output mhpq_pkg::seq_stat_t                                 stat,
  output mhpq_pkg::out_word_t                                 rsp,
  output logic                                                ram_we,
  output logic [((HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1)-1:0] ram_waddr,
  output mhpq_pkg::task_t                                     ram_wdata,
  output logic [((HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1)-1:0] ram_raddr,
  input  wire mhpq_pkg::task_t                                ram_rdata
);
  import mhpq_pkg::*;

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_EX_ROOT = 4'd3;
  localparam logic [3:0] S_EX_LAST = 4'd4;
  localparam logic [3:0] S_DN_RDL  = 4'd5;
  localparam logic [3:0] S_DN_RDR  = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_RESP    = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  task_t               item_r, item_nxt;
  task_t               best_r, best_nxt;
  logic                lsel_r, lsel_nxt;
  logic                rvld_r, rvld_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  task_t               res_task_r, res_task_nxt;

  logic signed [PRI_W-1:0] cmp_a, cmp_b;
  logic                    cmp_gt;
  logic [IW-1:0]           left_ix, right_ix, cnt_ext;
  logic [AW-1:0]           parent_ix;
  logic [CW+OCC_W-1:0]     occ_ext;
  logic                    done;

  // the one comparator shared by every priority comparison
  assign cmp_gt = cmp_a > cmp_b;

  assign left_ix   = {1'b0, pos_r, 1'b1};
  assign right_ix  = left_ix + IW'(1);
  assign cnt_ext   = IW'(count_r);
  assign parent_ix = AW'((pos_r - AW'(1)) >> 1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    best_nxt       = best_r;
    lsel_nxt       = lsel_r;
    rvld_nxt       = rvld_r;
    res_status_nxt = res_status_r;
    res_task_nxt   = res_task_r;
    cmp_a          = item_r.pri;
    cmp_b          = ram_rdata.pri;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = item_r;
    ram_raddr      = '0;
    done           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          res_status_nxt = ST_OK;
          res_task_nxt   = '0;
          if (req.command == CMD_INSERT) begin
            if (count_r == CW'(HEAP_DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              item_nxt.id  = req.task_id;
              item_nxt.pri = req.priority_req;
              pos_nxt      = count_r[AW-1:0];
              count_nxt    = count_r + CW'(1);
              state_nxt    = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              count_nxt = count_r - CW'(1);
              ram_raddr = '0;
              state_nxt = S_EX_ROOT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = parent_ix;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // parent moves down into the hole while it is strictly lower
        ram_we = 1'b1;
        if (cmp_gt) begin
          ram_wdata = ram_rdata;
          pos_nxt   = parent_ix;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_EX_ROOT: begin
        res_task_nxt = ram_rdata;
        ram_raddr    = count_r[AW-1:0];
        state_nxt    = S_EX_LAST;
      end
      S_EX_LAST: begin
        item_nxt = ram_rdata;
        pos_nxt  = '0;
        if (count_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_DN_RDL;
        end
      end
      S_DN_RDL: begin
        if (left_ix >= cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = left_ix[AW-1:0];
          state_nxt = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmp_a     = ram_rdata.pri;
        cmp_b     = item_r.pri;
        lsel_nxt  = cmp_gt;
        best_nxt  = cmp_gt ? ram_rdata : item_r;
        rvld_nxt  = right_ix < cnt_ext;
        ram_raddr = right_ix[AW-1:0];
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        // right child wins only on strictly greater priority
        cmp_a  = ram_rdata.pri;
        cmp_b  = best_r.pri;
        ram_we = 1'b1;
        if (rvld_r && cmp_gt) begin
          ram_wdata = ram_rdata;
          pos_nxt   = right_ix[AW-1:0];
          state_nxt = S_DN_RDL;
        end else if (lsel_r) begin
          ram_wdata = best_r;
          pos_nxt   = left_ix[AW-1:0];
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (ctl.out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    item_r       <= item_nxt;
    best_r       <= best_nxt;
    lsel_r       <= lsel_nxt;
    rvld_r       <= rvld_nxt;
    res_status_r <= res_status_nxt;
    res_task_r   <= res_task_nxt;
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_r};

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = done;

  assign rsp.status       = res_status_r;
  assign rsp.out_task_id  = res_task_r.id;
  assign rsp.out_priority = res_task_r.pri;
  assign rsp.occupancy    = occ_ext[OCC_W-1:0];

  `MHPQ_ASSERT(a_count_max, clk, rst_n, count_r <= CW'(HEAP_DEPTH), "task count above depth")
  `MHPQ_ASSERT(a_hole_in_heap, clk, rst_n, (state_r == S_UP_CMP || state_r == S_DN_RDL) |-> (IW'(pos_r) < cnt_ext), "hole outside heap")
  `MHPQ_ASSERT_NEVER(a_write_idle, clk, rst_n, ram_we && (state_r == S_IDLE || state_r == S_RESP), "ram write outside a sift")
  `MHPQ_ASSERT(a_done_free, clk, rst_n, done |-> (ctl.out_free && state_r == S_RESP), "result word pushed into a full output")

endmodule
`default_nettype wire

[sv/max_heap_priority_queue_core.sv]
// top level of the max-heap priority queue core: heap ram, sequencer, output register
// depends on mhpq_pkg, mhpq_ram and mhpq_seq
//
// channel  dir  handshake          word
// in_      in   in_valid/in_stall  mhpq_pkg::in_word_t  (command, task_id, priority_req)
// out_     out  out_valid/out_stall mhpq_pkg::out_word_t (status, id, priority, occupancy)
//
// insert: reads and compares one parent per level climbed, then writes the task into the hole
// extract: reads the root, then the last task, then both children per level descended
// extract of the last task: reads the root and the last task only; the single ram read port serializes these reads
// empty extract and full insert: go straight to the result with no ram access
// in_stall is high while a command is in the sequencer; reset clears the count, the sequencer state and out_valid only
// a result word waits in the output register while the next command is taken
`default_nettype none
module max_heap_priority_queue_core #(
  parameter int unsigned HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mhpq_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mhpq_pkg::out_word_t      out_word
);
  import mhpq_pkg::*;

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

  seq_ctl_t  ctl;
  seq_stat_t stat;
  out_word_t rsp;
  logic      ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  task_t     ram_wdata, ram_rdata;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  assign in_stall     = !stat.idle;
  assign ctl.start    = in_valid && stat.idle;
  assign ctl.out_free = !out_valid_r || !out_stall;

  mhpq_ram #(
    .WIDTH ($bits(task_t)),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mhpq_seq #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .req       (in_word),
    .stat      (stat),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = rsp;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
